/* hw/rtl/dpf_pkg.sv */
// Shared constants and types for the duplicate packet filter.
package dpf_pkg;

  localparam int TABLE_DEPTH_DEF = 16;
  localparam int KEY_W           = 32;
  localparam int PORT_BITS       = 16;

  localparam logic [15:0] ALL_PORTS  = 16'hFFFF;
  localparam logic        ACT_CHECK  = 1'b0;
  localparam logic        ACT_FLUSH  = 1'b1;

  typedef logic [KEY_W-1:0] key_t;

  typedef struct packed {
    logic valid;
    logic hit;
  } chain_t;

endpackage

/* hw/rtl/dpf_cell.sv */
// One table cell: holds an entry, compares it with the search key, passes the hit flag on.
module dpf_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  dpf_pkg::key_t   key,
  input  dpf_pkg::chain_t chain_in,
  input  logic            wr_en,
  input  logic            clr,
  output dpf_pkg::chain_t chain_out
);

  dpf_pkg::key_t   entry_r;
  dpf_pkg::key_t   entry_nxt;
  dpf_pkg::chain_t chain_r;
  dpf_pkg::chain_t chain_nxt;

  always_comb begin
    entry_nxt = entry_r;
    if (clr) begin
      entry_nxt = '0;
    end else if (wr_en) begin
      entry_nxt = key;
    end
    chain_nxt.valid = chain_in.valid;
    chain_nxt.hit   = chain_in.hit | (entry_r == key);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r <= '0;
      chain_r <= '0;
    end else begin
      entry_r <= entry_nxt;
      chain_r <= chain_nxt;
    end
  end

  assign chain_out = chain_r;

endmodule

/* hw/rtl/duplicate_packet_filter_forward_core.sv */
// Top level of the duplicate packet filter: control, cell chain and result register.
//
// Input channel in_*: one item per valid/ready handshake. in_action selects a
// header check or a flush of the seen table. Result channel out_*: exactly one
// result per item, held in an output register until out_ready takes it.
// A check item walks the key through a chain of TABLE_DEPTH cells, one cell per
// cycle; the result is registered once the search ends and the output register
// is free, and in_ready rises with it, so a new item is taken only after the
// previous one has its result registered.
// A flush item clears all cells at once, in the same cycle as its result is
// registered; like a check, it waits for a free output register.
// New headers are written into the cell at the write pointer, which wraps.
// When the receiver stalls, a finished result waits in the output register;
// the block still accepts and searches the next item and holds it at the end
// of the search until the output register is free.
// Synchronous reset clears all entries to zero, the write pointer and all
// handshake state; no clearing pass is needed.
module duplicate_packet_filter_forward_core #(
  parameter int TABLE_DEPTH = dpf_pkg::TABLE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_action,
  input  logic [15:0] in_source_id,
  input  logic [7:0]  in_packet_type,
  input  logic [7:0]  in_sequence_req,
  input  logic [7:0]  in_hop_radius,
  input  logic [7:0]  in_rx_port,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_is_new,
  output logic        out_forward,
  output logic [15:0] out_forward_mask,
  output logic [7:0]  out_forward_radius
);

  localparam int PTR_W = $clog2(TABLE_DEPTH);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SRCH = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [PTR_W-1:0] wp_r, wp_nxt;
  logic             start_r, start_nxt;
  logic             hit_r, hit_nxt;
  logic             flush_r, flush_nxt;
  dpf_pkg::key_t    key_r, key_nxt;
  logic [7:0]       radius_r, radius_nxt;
  logic [7:0]       port_r, port_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic             out_is_new_r, out_is_new_nxt;
  logic             out_forward_r, out_forward_nxt;
  logic [15:0]      out_mask_r, out_mask_nxt;
  logic [7:0]       out_radius_r, out_radius_nxt;

  dpf_pkg::chain_t  chain [TABLE_DEPTH+1];
  logic             in_acc;
  logic             out_load;
  logic             wr_go;
  logic             clr_go;
  logic             is_new;
  logic             fwd;

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_ready);
  assign is_new   = !flush_r && !hit_r;
  assign fwd      = is_new && (radius_r > 8'd1);
  assign wr_go    = out_load && is_new;
  assign clr_go   = out_load && flush_r;

  assign chain[0].valid = start_r;
  assign chain[0].hit   = 1'b0;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    localparam logic [PTR_W-1:0] IDX = PTR_W'(i);
    dpf_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .key       (key_r),
      .chain_in  (chain[i]),
      .wr_en     (wr_go && (wp_r == IDX)),
      .clr       (clr_go),
      .chain_out (chain[i+1])
    );
  end

  always_comb begin
    state_nxt      = state_r;
    wp_nxt         = wp_r;
    start_nxt      = 1'b0;
    hit_nxt        = hit_r;
    flush_nxt      = flush_r;
    key_nxt        = key_r;
    radius_nxt     = radius_r;
    port_nxt       = port_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_is_new_nxt = out_is_new_r;
    out_forward_nxt = out_forward_r;
    out_mask_nxt   = out_mask_r;
    out_radius_nxt = out_radius_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          key_nxt    = {in_source_id, in_packet_type, in_sequence_req};
          radius_nxt = in_hop_radius;
          port_nxt   = in_rx_port;
          flush_nxt  = (in_action == dpf_pkg::ACT_FLUSH);
          hit_nxt    = 1'b0;
          if (in_action == dpf_pkg::ACT_FLUSH) begin
            state_nxt = S_DONE;
          end else begin
            start_nxt = 1'b1;
            state_nxt = S_SRCH;
          end
        end
      end
      S_SRCH: begin
        if (chain[TABLE_DEPTH].valid) begin
          hit_nxt   = chain[TABLE_DEPTH].hit;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          out_valid_nxt   = 1'b1;
          out_is_new_nxt  = is_new;
          out_forward_nxt = fwd;
          out_mask_nxt    = '0;
          out_radius_nxt  = '0;
          if (fwd) begin
            out_radius_nxt = radius_r - 8'd1;
            if (port_r < 8'(dpf_pkg::PORT_BITS)) begin
              out_mask_nxt = dpf_pkg::ALL_PORTS & ~(16'd1 << port_r[3:0]);
            end else begin
              out_mask_nxt = dpf_pkg::ALL_PORTS;
            end
          end
          if (is_new) begin
            wp_nxt = (wp_r == PTR_W'(TABLE_DEPTH - 1)) ? '0 : wp_r + PTR_W'(1);
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wp_r        <= '0;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      start_r     <= start_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hit_r         <= hit_nxt;
    flush_r       <= flush_nxt;
    key_r         <= key_nxt;
    radius_r      <= radius_nxt;
    port_r        <= port_nxt;
    out_is_new_r  <= out_is_new_nxt;
    out_forward_r <= out_forward_nxt;
    out_mask_r    <= out_mask_nxt;
    out_radius_r  <= out_radius_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_is_new         = out_is_new_r;
  assign out_forward        = out_forward_r;
  assign out_forward_mask   = out_mask_r;
  assign out_forward_radius = out_radius_r;

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the duplicate packet filter with a seen-table scoreboard.
`timescale 1ns / 1ps

typedef struct packed {
  logic        is_new;
  logic        forward;
  logic [15:0] forward_mask;
  logic [7:0]  forward_radius;
} verdict_t;

class seen_table_model;
  dpf_pkg::key_t seen [dpf_pkg::TABLE_DEPTH_DEF];
  int unsigned   wr_ptr;
  verdict_t      expected_verdicts[$];
  int unsigned   errors;
  int unsigned   headers;
  int unsigned   flushes;
  int unsigned   new_headers;
  int unsigned   forwarded;

  function new();
    foreach (seen[i]) seen[i] = '0;
    wr_ptr      = 0;
    errors      = 0;
    headers     = 0;
    flushes     = 0;
    new_headers = 0;
    forwarded   = 0;
  endfunction

  function void note_header(logic act, logic [15:0] src, logic [7:0] typ,
                            logic [7:0] seq, logic [7:0] rad, logic [7:0] port);
    verdict_t      v;
    dpf_pkg::key_t key;
    logic          hit;
    v = '0;
    if (act == dpf_pkg::ACT_FLUSH) begin
      foreach (seen[i]) seen[i] = '0;
      flushes++;
    end else begin
      headers++;
      key = {src, typ, seq};
      hit = 1'b0;
      foreach (seen[i]) if (seen[i] == key) hit = 1'b1;
      if (!hit) begin
        seen[wr_ptr] = key;
        wr_ptr = (wr_ptr + 1) % dpf_pkg::TABLE_DEPTH_DEF;
        v.is_new = 1'b1;
        new_headers++;
        if (rad > 8'd1) begin
          v.forward      = 1'b1;
          v.forward_mask = dpf_pkg::ALL_PORTS;
          if (port < dpf_pkg::PORT_BITS) v.forward_mask[port[3:0]] = 1'b0;
          v.forward_radius = rad - 8'd1;
          forwarded++;
        end
      end
    end
    expected_verdicts.push_back(v);
  endfunction

  function void check_verdict(logic is_new, logic forward, logic [15:0] mask,
                              logic [7:0] radius);
    verdict_t v;
    if (expected_verdicts.size() == 0) begin
      $error("result with no item pending: is_new=%0d forward=%0d mask=%h radius=%0d",
             is_new, forward, mask, radius);
      errors++;
      return;
    end
    v = expected_verdicts.pop_front();
    if (is_new !== v.is_new) begin
      $error("is_new expected %0d actual %0d", v.is_new, is_new);
      errors++;
    end
    if (forward !== v.forward) begin
      $error("forward expected %0d actual %0d", v.forward, forward);
      errors++;
    end
    if (mask !== v.forward_mask) begin
      $error("forward_mask expected %h actual %h", v.forward_mask, mask);
      errors++;
    end
    if (radius !== v.forward_radius) begin
      $error("forward_radius expected %0d actual %0d", v.forward_radius, radius);
      errors++;
    end
  endfunction

  function int unsigned pending();
    return expected_verdicts.size();
  endfunction
endclass

module testbench;
  localparam int RANDOM_ITEMS = 1700;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_action = dpf_pkg::ACT_CHECK;
  logic [15:0] in_source_id = '0;
  logic [7:0]  in_packet_type = '0;
  logic [7:0]  in_sequence_req = '0;
  logic [7:0]  in_hop_radius = '0;
  logic [7:0]  in_rx_port = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_is_new;
  logic        out_forward;
  logic [15:0] out_forward_mask;
  logic [7:0]  out_forward_radius;

  int unsigned     idle_pct;
  int unsigned     stall_pct;
  seen_table_model sb;
  dpf_pkg::key_t   recent_keys[$];

  duplicate_packet_filter_forward_core #(
    .TABLE_DEPTH(dpf_pkg::TABLE_DEPTH_DEF)
  ) u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_action          (in_action),
    .in_source_id       (in_source_id),
    .in_packet_type     (in_packet_type),
    .in_sequence_req    (in_sequence_req),
    .in_hop_radius      (in_hop_radius),
    .in_rx_port         (in_rx_port),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_is_new         (out_is_new),
    .out_forward        (out_forward),
    .out_forward_mask   (out_forward_mask),
    .out_forward_radius (out_forward_radius)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready)
        sb.note_header(in_action, in_source_id, in_packet_type, in_sequence_req,
                       in_hop_radius, in_rx_port);
      if (out_valid && out_ready)
        sb.check_verdict(out_is_new, out_forward, out_forward_mask, out_forward_radius);
    end
  end

  task automatic send_header(input logic act, input logic [15:0] src,
                             input logic [7:0] typ, input logic [7:0] seq,
                             input logic [7:0] rad, input logic [7:0] port);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid        <= 1'b1;
    in_action       <= act;
    in_source_id    <= src;
    in_packet_type  <= typ;
    in_sequence_req <= seq;
    in_hop_radius   <= rad;
    in_rx_port      <= port;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_random_header();
    int unsigned   sel;
    dpf_pkg::key_t key;
    logic [7:0]    rad;
    logic [7:0]    port;
    sel = $urandom_range(99);
    rad = ($urandom_range(99) < 30) ? 8'($urandom_range(3)) : 8'($urandom_range(255));
    port = ($urandom_range(1)) ? 8'($urandom_range(17)) : 8'($urandom_range(255));
    if (sel < 3) begin
      key = $urandom;
      send_header(dpf_pkg::ACT_FLUSH, key[31:16], key[15:8], key[7:0], rad, port);
      return;
    end
    if (sel < 45 && recent_keys.size() != 0)
      key = recent_keys[$urandom_range(recent_keys.size() - 1)];
    else if (sel < 50)
      key = '0;
    else if (sel < 75)
      key = {16'($urandom_range(7)), 8'($urandom_range(3)), 8'($urandom_range(15))};
    else
      key = $urandom;
    recent_keys.push_back(key);
    if (recent_keys.size() > 24) void'(recent_keys.pop_front());
    send_header(dpf_pkg::ACT_CHECK, key[31:16], key[15:8], key[7:0], rad, port);
  endtask

  initial begin
    sb        = new();
    idle_pct  = 12;
    stall_pct = 71;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // cleared table, extreme fields, mask and radius corners, flush
    send_header(dpf_pkg::ACT_CHECK, 16'h0000, 8'h00, 8'h00, 8'd5,   8'd0);
    send_header(dpf_pkg::ACT_CHECK, 16'hFFFF, 8'hFF, 8'hFF, 8'd255, 8'd0);
    send_header(dpf_pkg::ACT_CHECK, 16'hFFFF, 8'hFF, 8'hFF, 8'd255, 8'd0);
    send_header(dpf_pkg::ACT_CHECK, 16'h0001, 8'h00, 8'h00, 8'd0,   8'd15);
    send_header(dpf_pkg::ACT_CHECK, 16'h0002, 8'h00, 8'h00, 8'd1,   8'd3);
    send_header(dpf_pkg::ACT_CHECK, 16'h0003, 8'h00, 8'h00, 8'd2,   8'd15);
    send_header(dpf_pkg::ACT_CHECK, 16'h0004, 8'h00, 8'h00, 8'd2,   8'd16);
    send_header(dpf_pkg::ACT_CHECK, 16'h0005, 8'h00, 8'h00, 8'd2,   8'd255);
    send_header(dpf_pkg::ACT_CHECK, 16'h0000, 8'hFF, 8'h00, 8'd3,   8'd7);
    send_header(dpf_pkg::ACT_CHECK, 16'h0000, 8'h00, 8'hFF, 8'd3,   8'd8);
    send_header(dpf_pkg::ACT_CHECK, 16'h0003, 8'h00, 8'h00, 8'd9,   8'd1);
    send_header(dpf_pkg::ACT_FLUSH, 16'hFFFF, 8'hFF, 8'hFF, 8'd255, 8'd255);
    send_header(dpf_pkg::ACT_CHECK, 16'hFFFF, 8'hFF, 8'hFF, 8'd128, 8'd10);
    send_header(dpf_pkg::ACT_CHECK, 16'h0000, 8'h00, 8'h00, 8'd2,   8'd0);
    send_header(dpf_pkg::ACT_CHECK, 16'h0003, 8'h00, 8'h00, 8'd9,   8'd1);
    send_header(dpf_pkg::ACT_FLUSH, 16'h0000, 8'h00, 8'h00, 8'd0,   8'd0);
    send_header(dpf_pkg::ACT_CHECK, 16'h0003, 8'h00, 8'h00, 8'd9,   8'd1);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 3) begin
        idle_pct  = 71;
        stall_pct = 12;
      end else if (i == 2 * RANDOM_ITEMS / 3) begin
        idle_pct  = 0;
        stall_pct = 0;
      end
      send_random_header();
    end
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (dpf_pkg::TABLE_DEPTH_DEF + 8) @(posedge clk);

    $display("summary: %0d header checks (%0d new, %0d forwarded) and %0d flushes",
             sb.headers, sb.new_headers, sb.forwarded, sb.flushes);
    $display("summary: three idle/stall mixes, %0d mismatches", sb.errors);
    if (sb.errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  initial begin
    #1_000_000;
    $display("tb: failure");
    $finish;
  end
endmodule
